// ===== rtl/core/ilct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilct_pkg
// Shared types and constants for the image line cache tag controller.
// ----------------------------------------------------------------------------
package ilct_pkg;
  localparam int SlotCount = 256;
  localparam int RowBits = 12;
  localparam int SlotBits = 8;
  localparam int CountBits = 9;

  localparam logic [1:0] STATUS_HIT = 2'd0;
  localparam logic [1:0] STATUS_NEW = 2'd1;
  localparam logic [1:0] STATUS_REPLACE = 2'd2;
  localparam logic [1:0] STATUS_WINDOW = 2'd3;

  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_WINDOW = 1'b1;

  localparam logic CFG_IMAGE_HEIGHT = 1'b0;
  localparam logic CFG_SLOT_LIMIT = 1'b1;

  typedef struct packed {
    logic req_type;
    logic [11:0] row_number;
    logic [11:0] window_top;
    logic [11:0] dest_height;
    logic [11:0] window_height;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot_index;
    logic fill_request;
  } resp_t;

  typedef struct packed {
    logic [0:0] index;
    logic [11:0] data;
  } cfg_t;
endpackage

// ===== rtl/core/ilct_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilct_req_if / ilct_resp_if / ilct_cfg_if
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface ilct_req_if;
  import ilct_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ilct_resp_if;
  import ilct_pkg::*;
  logic valid;
  logic ready;
  resp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ilct_cfg_if;
  import ilct_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ilct_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilct_div
// Restoring divider, one quotient bit per cycle, 24-bit dividend / 12-bit.
// ----------------------------------------------------------------------------
module ilct_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [11:0] divisor,
  output logic        done,
  output logic [23:0] quotient
);
  logic [23:0] quo;
  logic [12:0] rem;
  logic [11:0] dvs;
  logic [4:0] count;
  logic busy;
  logic [12:0] trial;
  logic [12:0] diff;

  assign trial = {rem[11:0], quo[23]};
  assign diff = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'd0;
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (busy) begin
        if (!diff[12]) begin
          rem <= diff;
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[22:0], 1'b0};
        end
        count <= count + 5'd1;
        if (count == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/image_line_cache_tags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_line_cache_tags
// Tag controller for a cache of decoded image rows.
// ----------------------------------------------------------------------------
// One item at a time. A read scans the slots in use, reading their tags from a
// tag RAM, then scans again for a victim when full. A window update runs the
// shared serial divider once for the window bottom and twice per slot.
// The result sits in an output register until taken.
module image_line_cache_tags (
  input logic clk,
  input logic rst,
  ilct_req_if.sink  req,
  ilct_resp_if.source resp,
  ilct_cfg_if.sink  cfg
);
  import ilct_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HSCAN = 4'd1;
  localparam logic [3:0] S_HCHK = 4'd2;
  localparam logic [3:0] S_VSCAN = 4'd3;
  localparam logic [3:0] S_VCHK = 4'd4;
  localparam logic [3:0] S_BOT = 4'd5;
  localparam logic [3:0] S_WRD = 4'd6;
  localparam logic [3:0] S_WD1 = 4'd7;
  localparam logic [3:0] S_WD2 = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_WCHK = 4'd10;

  logic [3:0] state;
  logic [11:0] image_height;
  logic [8:0] slot_limit;
  logic [8:0] slots_in_use;
  logic empty_mark [SlotCount];
  logic mark_q;
  logic [RowBits-1:0] tag_ram [SlotCount];
  logic [RowBits-1:0] tag_q;
  logic [8:0] idx;
  logic [7:0] best;
  logic [RowBits-1:0] best_tag;
  req_t r;
  logic [11:0] h_eff;
  logic [11:0] dh_eff;
  logic [12:0] bottom;
  logic [23:0] q1;
  logic div_start;
  logic [23:0] div_a;
  logic [11:0] div_b;
  logic div_done;
  logic [23:0] div_q;
  logic [8:0] limit;
  logic [12:0] line_p1;

  ilct_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  assign limit = (slot_limit > 9'(SlotCount)) ? 9'(SlotCount) : slot_limit;
  assign req.ready = (state == S_IDLE) && !resp.valid;
  assign cfg.ready = 1'b1;
  assign line_p1 = {1'b0, tag_q} + 13'd1;

  always_ff @(posedge clk) begin
    tag_q <= tag_ram[idx[7:0]];
    mark_q <= empty_mark[idx[7:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      image_height <= 12'd1;
      slot_limit <= 9'd256;
      slots_in_use <= '0;
      resp.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (resp.valid && resp.ready) resp.valid <= 1'b0;
      if (cfg.valid) begin
        unique case (cfg.data.index)
          CFG_IMAGE_HEIGHT: image_height <= cfg.data.data;
          CFG_SLOT_LIMIT:   slot_limit <= cfg.data.data[8:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            r <= req.data;
            idx <= '0;
            h_eff <= (image_height == 12'd0) ? 12'd1 : image_height;
            dh_eff <= (req.data.dest_height == 12'd0) ? 12'd1 : req.data.dest_height;
            if (req.data.req_type == REQ_READ) state <= S_HSCAN;
            else begin
              div_a <= 24'(req.data.window_height) *
                       24'((image_height == 12'd0) ? 12'd1 : image_height);
              div_b <= (req.data.dest_height == 12'd0) ? 12'd1 : req.data.dest_height;
              div_start <= 1'b1;
              state <= S_BOT;
            end
          end
        end
        S_HSCAN: begin
          if (idx < slots_in_use) state <= S_HCHK;
          else if (slots_in_use < limit) begin
            tag_ram[slots_in_use[7:0]] <= r.row_number;
            empty_mark[slots_in_use[7:0]] <= 1'b0;
            slots_in_use <= slots_in_use + 9'd1;
            resp.data <= '{STATUS_NEW, slots_in_use[7:0], 1'b1};
            state <= S_OUT;
          end else if (slots_in_use == 9'd0) begin
            resp.data <= '{STATUS_REPLACE, 8'd0, 1'b0};
            state <= S_OUT;
          end else begin
            idx <= '0;
            best <= '0;
            state <= S_VSCAN;
          end
        end
        S_HCHK: begin
          if (tag_q == r.row_number) begin
            resp.data <= '{STATUS_HIT, idx[7:0], 1'b0};
            state <= S_OUT;
          end else begin
            idx <= idx + 9'd1;
            state <= S_HSCAN;
          end
        end
        S_VSCAN: begin
          if (idx < slots_in_use) state <= S_VCHK;
          else begin
            tag_ram[best] <= r.row_number;
            empty_mark[best] <= 1'b0;
            resp.data <= '{STATUS_REPLACE, best, 1'b1};
            state <= S_OUT;
          end
        end
        S_VCHK: begin
          if (mark_q) begin
            tag_ram[idx[7:0]] <= r.row_number;
            empty_mark[idx[7:0]] <= 1'b0;
            resp.data <= '{STATUS_REPLACE, idx[7:0], 1'b1};
            state <= S_OUT;
          end else begin
            if (idx == 9'd0 || tag_q < best_tag) begin
              best <= idx[7:0];
              best_tag <= tag_q;
            end
            idx <= idx + 9'd1;
            state <= S_VSCAN;
          end
        end
        S_BOT: begin
          if (div_done) begin
            // a span past the last row keeps every row inside
            bottom <= (|div_q[23:12]) ? 13'h1FFF :
                      {1'b0, r.window_top} + {1'b0, div_q[11:0]};
            state <= S_WRD;
          end
        end
        S_WRD: begin
          if (idx < slots_in_use) state <= S_WCHK;
          else begin
            resp.data <= '{STATUS_WINDOW, 8'd0, 1'b0};
            state <= S_OUT;
          end
        end
        S_WCHK: begin
          div_a <= 24'(tag_q) * 24'(dh_eff);
          div_b <= h_eff;
          div_start <= 1'b1;
          state <= S_WD1;
        end
        S_WD1: begin
          if (div_done) begin
            q1 <= div_q;
            div_a <= 24'(line_p1) * 24'(dh_eff);
            div_start <= 1'b1;
            state <= S_WD2;
          end
        end
        S_WD2: begin
          if (div_done) begin
            empty_mark[idx[7:0]] <= (tag_q < r.window_top) ||
                                    ({1'b0, tag_q} > bottom) || (q1 == div_q);
            idx <= idx + 9'd1;
            state <= S_WRD;
          end
        end
        S_OUT: begin
          resp.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== test/tb_image_line_cache_tags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_line_cache_tags
// Self-checking bench for the image row cache tag controller. A table of
// directed requests and register writes comes first. Phases of random reads
// and window updates follow under a list of slot limits. A tag-cache model
// predicts results the table leaves open. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_image_line_cache_tags;
  import ilct_pkg::*;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;
  typedef struct {
    row_kind_e kind;
    logic cfg_index;
    logic [11:0] cfg_data;
    req_t item;
    bit typed;
    resp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  ilct_req_if req_ch ();
  ilct_resp_if resp_ch ();
  ilct_cfg_if cfg_ch ();

  image_line_cache_tags u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .resp(resp_ch.source),
    .cfg (cfg_ch.sink)
  );

  logic [11:0] tag_row[SlotCount];
  bit empty_mark[SlotCount];
  int unsigned used_slots;
  int unsigned img_height;
  int unsigned limit_reg;

  resp_t pending_results[$];
  dir_row_t dir_tab[$];
  int errors;
  bit quiet;
  int n_read, n_window, n_hit, n_new, n_replace, n_results;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("FAIL image_line_cache_tags");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void cache_reset();
    for (int i = 0; i < SlotCount; i++) begin
      tag_row[i] = '0;
      empty_mark[i] = 1'b0;
    end
    used_slots = 0;
    img_height = 1;
    limit_reg = 256;
  endfunction

  function automatic void cache_write_reg(input logic idx, input logic [11:0] val);
    if (idx == CFG_IMAGE_HEIGHT) img_height = 32'(val);
    else limit_reg = 32'(val[8:0]);
  endfunction

  function automatic resp_t cache_lookup(input req_t r);
    resp_t o;
    int unsigned lim, victim;
    longint unsigned top, dh, ch, h, bottom, line;
    bit found;
    o = '0;
    if (r.req_type == REQ_READ) begin
      n_read++;
      found = 1'b0;
      for (int i = 0; i < used_slots; i++)
        if (!found && tag_row[i] == r.row_number) begin
          found = 1'b1;
          o.status = STATUS_HIT;
          o.slot_index = i[7:0];
        end
      if (found) begin
        n_hit++;
        return o;
      end
      lim = (limit_reg > SlotCount) ? SlotCount : limit_reg;
      if (used_slots < lim) begin
        tag_row[used_slots] = r.row_number;
        empty_mark[used_slots] = 1'b0;
        o.status = STATUS_NEW;
        o.slot_index = used_slots[7:0];
        o.fill_request = 1'b1;
        used_slots++;
        n_new++;
        return o;
      end
      o.status = STATUS_REPLACE;
      if (used_slots == 0) return o;
      victim = 0;
      found = 1'b0;
      for (int i = 0; i < used_slots; i++)
        if (!found) begin
          if (empty_mark[i]) begin
            victim = i;
            found = 1'b1;
          end else if (tag_row[i] < tag_row[victim]) begin
            victim = i;
          end
        end
      tag_row[victim] = r.row_number;
      empty_mark[victim] = 1'b0;
      o.slot_index = victim[7:0];
      o.fill_request = 1'b1;
      n_replace++;
    end else begin
      n_window++;
      top = r.window_top;
      dh = (r.dest_height == 0) ? 1 : r.dest_height;
      ch = r.window_height;
      h = (img_height == 0) ? 1 : img_height;
      bottom = top + (ch * h) / dh;
      for (int i = 0; i < used_slots; i++) begin
        line = tag_row[i];
        empty_mark[i] = (line < top) || (line > bottom) ||
                        ((line * dh) / h == ((line + 1) * dh) / h);
      end
      o.status = STATUS_WINDOW;
    end
    return o;
  endfunction

  task automatic idle_gap();
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 99) < 55) ? 0 : $urandom_range(1, 15));
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(input req_t r, input bit typed, input resp_t want);
    resp_t p;
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = cache_lookup(r);
    pending_results.push_back(typed ? want : p);
    idle_gap();
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cache_write_reg(idx, val);
  endtask

  function automatic req_t mk_read(input logic [11:0] row);
    req_t r;
    r = '0;
    r.req_type = REQ_READ;
    r.row_number = row;
    return r;
  endfunction

  function automatic req_t mk_window(input logic [11:0] top, input logic [11:0] dh,
                                     input logic [11:0] wh);
    req_t r;
    r = '0;
    r.req_type = REQ_WINDOW;
    r.window_top = top;
    r.dest_height = dh;
    r.window_height = wh;
    return r;
  endfunction

  function automatic void add_cfg(input logic idx, input logic [11:0] val);
    dir_row_t d;
    d = '{kind: ROW_CFG, cfg_index: idx, cfg_data: val, item: '0, typed: 0, want: '0};
    dir_tab.push_back(d);
  endfunction

  function automatic void add_req(input req_t r, input bit typed, input logic [1:0] st,
                                  input logic [7:0] slot, input logic fill);
    dir_row_t d;
    d = '{kind: ROW_REQ, cfg_index: 1'b0, cfg_data: '0, item: r, typed: typed,
          want: '{status: st, slot_index: slot, fill_request: fill}};
    dir_tab.push_back(d);
  endfunction

  function automatic logic [11:0] pick_row();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 12'($urandom_range(0, 40));
    if (sel < 65) return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic req_t rand_item(input int win_pct);
    req_t r;
    r.req_type = ($urandom_range(0, 99) < win_pct) ? REQ_WINDOW : REQ_READ;
    r.row_number = pick_row();
    r.window_top = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 30)) :
                   12'($urandom_range(0, 4095));
    r.dest_height = ($urandom_range(0, 19) == 0) ? 12'd0 :
                    (($urandom_range(0, 1) != 0) ? 12'($urandom_range(1, 64)) :
                     12'($urandom_range(1, 4095)));
    r.window_height = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 64)) :
                      12'($urandom_range(0, 4095));
    return r;
  endfunction

  initial begin
    resp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      int len;
      bit on;
      len = $urandom_range(1, 15);
      on = quiet || ($urandom_range(0, 99) < 65);
      resp_ch.ready <= on;
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    resp_t w;
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", resp_ch.data));
      end else begin
        w = pending_results.pop_front();
        if (resp_ch.data.status !== w.status)
          report_mismatch($sformatf("status %0d want %0d", resp_ch.data.status, w.status));
        if (resp_ch.data.slot_index !== w.slot_index)
          report_mismatch($sformatf("slot %0d want %0d", resp_ch.data.slot_index,
                                    w.slot_index));
        if (resp_ch.data.fill_request !== w.fill_request)
          report_mismatch($sformatf("fill %0b want %0b", resp_ch.data.fill_request,
                                    w.fill_request));
      end
    end
  end

  initial begin
    int limits[10] = '{4, 9, 16, 0, 3, 32, 511, 48, 64, 256};
    int count;
    int win_pct;
    logic [11:0] h;
    errors = 0;
    quiet = 1'b0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    cache_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_cfg(CFG_SLOT_LIMIT, 12'd0);
    add_req(mk_read(12'd7), 1, STATUS_REPLACE, 8'd0, 1'b0);
    add_cfg(CFG_SLOT_LIMIT, 12'd1);
    add_req(mk_read(12'd7), 1, STATUS_NEW, 8'd0, 1'b1);
    add_req(mk_read(12'd7), 1, STATUS_HIT, 8'd0, 1'b0);
    add_req(mk_read(12'hFFF), 1, STATUS_REPLACE, 8'd0, 1'b1);
    add_req(mk_window(12'd0, 12'd1, 12'd0), 1, STATUS_WINDOW, 8'd0, 1'b0);
    add_req(mk_read(12'd0), 0, STATUS_HIT, 8'd0, 1'b0);
    add_cfg(CFG_IMAGE_HEIGHT, 12'hFFF);
    add_cfg(CFG_SLOT_LIMIT, 12'h1FF);
    add_req(mk_read(12'hFFF), 1, STATUS_NEW, 8'd1, 1'b1);
    add_req(mk_read(12'd0), 0, STATUS_HIT, 8'd0, 1'b0);
    add_req(mk_window(12'd0, 12'hFFF, 12'hFFF), 1, STATUS_WINDOW, 8'd0, 1'b0);
    add_req(mk_window(12'hFFF, 12'd0, 12'd0), 1, STATUS_WINDOW, 8'd0, 1'b0);
    add_req(mk_read(12'd100), 0, STATUS_HIT, 8'd0, 1'b0);
    add_cfg(CFG_IMAGE_HEIGHT, 12'd0);
    add_req(mk_window(12'd0, 12'd0, 12'hFFF), 1, STATUS_WINDOW, 8'd0, 1'b0);
    add_cfg(CFG_SLOT_LIMIT, 12'd2);
    add_req(mk_read(12'd200), 0, STATUS_HIT, 8'd0, 1'b0);
    add_req(mk_window(12'hFFF, 12'hFFF, 12'hFFF), 1, STATUS_WINDOW, 8'd0, 1'b0);
    add_req(mk_read(12'd300), 0, STATUS_HIT, 8'd0, 1'b0);
    add_req(mk_read(12'd100), 0, STATUS_HIT, 8'd0, 1'b0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].cfg_index, dir_tab[i].cfg_data);
      else send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    end

    foreach (limits[p]) begin
      case ($urandom_range(0, 4))
        0: h = 12'd1;
        1: h = 12'hFFF;
        2: h = 12'd0;
        default: h = 12'($urandom_range(1, 200));
      endcase
      write_reg(CFG_IMAGE_HEIGHT, h);
      write_reg(CFG_SLOT_LIMIT, 12'(limits[p]));
      quiet = (p == 9);
      win_pct = (limits[p] >= 256) ? 3 : 15;
      count = (p == 9) ? 150 : 140;
      for (int k = 0; k < count; k++) send_item(rand_item(win_pct), 0, '0);
    end
    req_ch.valid <= 1'b0;

    count = 0;
    while (pending_results.size() != 0 && count < 200000) begin
      @(posedge clk);
      count++;
    end
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("run: %0d reads (%0d hits, %0d new, %0d replaced), %0d window updates",
             n_read, n_hit, n_new, n_replace, n_window);
    $display("run: %0d results checked, %0d slots in use at end, %0d errors",
             n_results, used_slots, errors);
    if (errors == 0) begin
      $display("PASS image_line_cache_tags");
    end else begin
      $display("FAIL image_line_cache_tags");
    end
    $finish;
  end
endmodule

// ===== image_line_cache_tags.f =====
rtl/core/ilct_pkg.sv
rtl/core/ilct_if.sv
rtl/core/ilct_div.sv
rtl/core/image_line_cache_tags.sv
test/tb_image_line_cache_tags.sv
